/* rtl/pse_pkg.sv */
// shared types and codes for the postfix stack evaluator
// no dependencies; imported by pse_alu and postfix_stack_evaluator_top
package pse_pkg;

  localparam int NUMBER_W = 31;
  localparam int TOP_W    = 32;
  localparam int DEPTH_W  = 5;
  localparam int STATUS_W = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_DIV = 2'd2,
    OP_MUL = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_OP   = 1'b1;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_ctrl_t;

endpackage

/* rtl/pse_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/pse_alu.sv */
// serial arithmetic unit: bit-serial add/subtract, shift-add multiply,
// restoring divide, one bit of the operand per cycle; uses pse_pkg
module pse_alu #(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pse_pkg::alu_ctrl_t ctrl,
  input  logic [W-1:0]       a,
  input  logic [W-1:0]       b,
  output logic               done,
  output logic [W-1:0]       result
);
  import pse_pkg::*;

  localparam int CW = $clog2(W);

  typedef enum logic [1:0] {A_IDLE, A_PREP, A_RUN, A_FIX} astate_t;

  astate_t       state_r, state_nxt;
  op_t           op_r, op_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic          carry_r, carry_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic          bb, sbit;
  logic [W:0]    rem_sh, diff;
  logic          qbit;

  always_comb begin
    bb     = b_r[0] ^ (op_r == OP_SUB);
    sbit   = a_r[0] ^ bb ^ carry_r;
    rem_sh = {acc_r, a_r[W-1]};
    diff   = rem_sh - {1'b0, b_r};
    qbit   = ~diff[W];

    state_nxt = state_r;
    op_nxt    = op_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    carry_nxt = carry_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;

    unique case (state_r)
      A_IDLE: begin
        if (ctrl.start) begin
          op_nxt    = ctrl.op;
          a_nxt     = a;
          b_nxt     = b;
          acc_nxt   = '0;
          carry_nxt = (ctrl.op == OP_SUB);
          cnt_nxt   = '0;
          state_nxt = (ctrl.op == OP_DIV) ? A_PREP : A_RUN;
        end
      end
      A_PREP: begin
        // divide works on magnitudes, sign restored at the end
        neg_nxt   = a_r[W-1] ^ b_r[W-1];
        a_nxt     = a_r[W-1] ? (~a_r + W'(1)) : a_r;
        b_nxt     = b_r[W-1] ? (~b_r + W'(1)) : b_r;
        state_nxt = A_RUN;
      end
      A_RUN: begin
        unique case (op_r)
          OP_ADD, OP_SUB: begin
            carry_nxt = (a_r[0] & bb) | (a_r[0] & carry_r) | (bb & carry_r);
            acc_nxt   = {sbit, acc_r[W-1:1]};
            a_nxt     = a_r >> 1;
            b_nxt     = b_r >> 1;
          end
          OP_MUL: begin
            acc_nxt = acc_r + (b_r[0] ? a_r : '0);
            a_nxt   = a_r << 1;
            b_nxt   = b_r >> 1;
          end
          OP_DIV: begin
            // quotient bits shift into a_r as dividend bits leave it
            acc_nxt = qbit ? diff[W-1:0] : rem_sh[W-1:0];
            a_nxt   = {a_r[W-2:0], qbit};
          end
          default: begin
            acc_nxt = acc_r;
          end
        endcase
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(W - 1)) begin
          state_nxt = A_FIX;
        end
      end
      A_FIX: begin
        state_nxt = A_IDLE;
      end
      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r    <= op_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    carry_r <= carry_nxt;
    neg_r   <= neg_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign done = (state_r == A_FIX);

  always_comb begin
    if (op_r == OP_DIV) begin
      result = neg_r ? (~a_r + W'(1)) : a_r;
    end else begin
      result = acc_r;
    end
  end

endmodule

/* rtl/postfix_stack_evaluator_top.sv */
// postfix evaluator: push or operator token in, one result item out per token.
// push and rejected tokens: the result is registered in the cycle after accept.
// operators: stack read, then the serial unit (plus a sign prep step for divide),
// then S_PUT; the serial unit handles one operand bit per cycle; one token at a time.
// synchronous active-low reset empties the stack; stack storage is not cleared.
// uses pse_pkg, pse_ram, pse_alu
module postfix_stack_evaluator_top #(
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pse_pkg::IN_DATA_W-1:0]    in_tdata,  // number[30:0], operation[32:31]
  input  logic                             in_tuser,  // kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pse_pkg::OUT_DATA_W-1:0]   out_tdata  // top_value[31:0], depth[36:32],
                                                      // status[38:37]
);
  import pse_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int VW    = VALUE_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC, S_PUT} state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0]    top_r, top_nxt;
  op_t              op_r, op_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [TOP_W-1:0] out_top_r, out_top_nxt;
  logic [DEPTH_W-1:0] out_depth_r, out_depth_nxt;
  status_t          out_status_r, out_status_nxt;

  logic [NUMBER_W-1:0] in_number;
  op_t              in_op;
  logic             in_fire;
  logic [VW-1:0]    num_v;
  logic             load_out;
  status_t          st;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr;
  logic [VW-1:0]    ram_wdata, ram_rdata;
  logic [CNT_W-1:0] cnt_m2;
  logic [AW-1:0]    sub_addr;
  alu_ctrl_t        alu_ctrl;
  logic             alu_done;
  logic [VW-1:0]    alu_res;
  logic [TOP_W-1:0] top_ext;
  logic [DEPTH_W-1:0] depth_ext;

  assign in_number = in_tdata[NUMBER_W-1:0];
  assign in_op     = op_t'(in_tdata[NUMBER_W+1:NUMBER_W]);
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign cnt_m2    = cnt_r - CNT_W'(2);
  assign sub_addr  = cnt_m2[AW-1:0];

  generate
    if (VW > NUMBER_W) begin : g_num_ext
      assign num_v = {{(VW - NUMBER_W){1'b0}}, in_number};
    end else begin : g_num_trunc
      assign num_v = in_number[VW-1:0];
    end
    if (VW < TOP_W) begin : g_top_ext
      assign top_ext = {{(TOP_W - VW){top_nxt[VW-1]}}, top_nxt};
    end else begin : g_top_trunc
      assign top_ext = top_nxt[TOP_W-1:0];
    end
    if (CNT_W >= DEPTH_W) begin : g_dep_trunc
      assign depth_ext = cnt_nxt[DEPTH_W-1:0];
    end else begin : g_dep_ext
      assign depth_ext = {{(DEPTH_W - CNT_W){1'b0}}, cnt_nxt};
    end
  endgenerate

  assign out_top_nxt   = (cnt_nxt == '0) ? '0 : top_ext;
  assign out_depth_nxt = depth_ext;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    top_nxt   = top_r;
    op_nxt    = op_r;
    load_out  = 1'b0;
    st        = ST_OK;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cnt_r[AW-1:0];
    ram_wdata = num_v;
    alu_ctrl.start = 1'b0;
    alu_ctrl.op    = op_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          priority if (in_tuser == KIND_PUSH) begin
            if (cnt_r == CNT_W'(STACK_DEPTH)) begin
              st = ST_OVER;
            end else begin
              ram_we  = 1'b1;
              top_nxt = num_v;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
            load_out = 1'b1;
          end else if (cnt_r < CNT_W'(2)) begin
            st       = ST_UNDER;
            load_out = 1'b1;
          end else if (in_op == OP_DIV && top_r == '0) begin
            st       = ST_DIVZ;
            load_out = 1'b1;
          end else begin
            // second operand is the cached top, fetch the first one
            ram_re    = 1'b1;
            op_nxt    = in_op;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        alu_ctrl.start = 1'b1;
        state_nxt      = S_CALC;
      end
      S_CALC: begin
        if (alu_done) begin
          ram_we    = 1'b1;
          ram_waddr = sub_addr;
          ram_wdata = alu_res;
          top_nxt   = alu_res;
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    out_status_nxt = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_r <= top_nxt;
    op_r  <= op_nxt;
    if (load_out) begin
      out_top_r    <= out_top_nxt;
      out_depth_r  <= out_depth_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  pse_ram #(
    .WIDTH(VW),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(sub_addr),
    .rdata(ram_rdata)
  );

  pse_alu #(
    .W(VW)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (alu_ctrl),
    .a     (ram_rdata),
    .b     (top_r),
    .done  (alu_done),
    .result(alu_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_status_r, out_depth_r, out_top_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> state_r == S_CALC)
    else $error("serial unit finished outside of calc");

  a_start_has_operands: assert property (@(posedge clk) disable iff (!rst_n)
    alu_ctrl.start |-> cnt_r >= CNT_W'(2))
    else $error("operator started with fewer than two entries");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == KIND_PUSH && cnt_r != CNT_W'(STACK_DEPTH))
      |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("push did not grow the stack");

endmodule

/* dv/tb_top.sv */
// self-checking bench for postfix_stack_evaluator_top: directed token table, then random tokens
// expected: table values or a local stack calculator; depends on rtl/pse_pkg.sv and the top level
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pse_pkg::*;

  localparam int STACK_DEPTH  = 16;
  localparam int PHASE_ITEMS  = 125;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_CYCLES   = 400000;

  typedef struct packed {
    logic [TOP_W-1:0]   top;
    logic [DEPTH_W-1:0] depth;
    status_t            status;
  } result_t;

  typedef struct packed {
    logic                kind;
    logic [NUMBER_W-1:0] number;
    op_t                 op;
    bit                  known;
    result_t             res;
    int                  reps;
  } token_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // calculator state mirrored from the accepted tokens
  logic [TOP_W-1:0] stack_mem [STACK_DEPTH];
  int unsigned      stack_cnt = 0;

  result_t    pending_results [$];
  token_row_t token_plan [$];
  int         mismatch_cnt = 0;
  int         cycle_cnt    = 0;
  int         idle_pct     = 0;
  int         stall_pct    = 0;

  postfix_stack_evaluator_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= stall_pct);
  end

  function automatic result_t rpn_eval(logic kind, logic [NUMBER_W-1:0] number, op_t op);
    result_t          r;
    logic [TOP_W-1:0] lhs, rhs, mag_l, mag_r, val;
    r.status = ST_OK;
    if (kind == KIND_PUSH) begin
      if (stack_cnt >= STACK_DEPTH) begin
        r.status = ST_OVER;
      end else begin
        stack_mem[stack_cnt] = {1'b0, number};
        stack_cnt++;
      end
    end else if (stack_cnt < 2) begin
      r.status = ST_UNDER;
    end else begin
      rhs = stack_mem[stack_cnt-1];
      lhs = stack_mem[stack_cnt-2];
      if (op == OP_DIV && rhs == '0) begin
        r.status = ST_DIVZ;
      end else begin
        case (op)
          OP_ADD: val = lhs + rhs;
          OP_SUB: val = lhs - rhs;
          OP_MUL: val = lhs * rhs;
          default: begin
            // unsigned magnitudes keep min / -1 from trapping, sign restored after
            mag_l = lhs[TOP_W-1] ? -lhs : lhs;
            mag_r = rhs[TOP_W-1] ? -rhs : rhs;
            val = mag_l / mag_r;
            if (lhs[TOP_W-1] != rhs[TOP_W-1]) val = -val;
          end
        endcase
        stack_mem[stack_cnt-2] = val;
        stack_cnt--;
      end
    end
    r.top   = (stack_cnt > 0) ? stack_mem[stack_cnt-1] : '0;
    r.depth = stack_cnt[DEPTH_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [TOP_W-1:0] got, logic [TOP_W-1:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin : result_check
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.top    = out_tdata[31:0];
      got.depth  = out_tdata[36:32];
      got.status = status_t'(out_tdata[38:37]);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result item, top", got.top, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.top !== want.top) report_mismatch("top_value", got.top, want.top);
        if (got.depth !== want.depth) begin
          report_mismatch("depth", TOP_W'(got.depth), TOP_W'(want.depth));
        end
        if (got.status !== want.status) begin
          report_mismatch("status", TOP_W'(got.status), TOP_W'(want.status));
        end
      end
    end
  end

  task automatic send_token(logic kind, logic [NUMBER_W-1:0] number, op_t op,
                            bit known, result_t typed);
    result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {7'b0, op, number};
    do @(posedge clk); while (!in_tready);
    predicted = rpn_eval(kind, number, op);
    pending_results.push_back(known ? typed : predicted);
  endtask

  task automatic add_row(logic kind, logic [NUMBER_W-1:0] number, op_t op, bit known,
                         logic [TOP_W-1:0] top, logic [DEPTH_W-1:0] depth, status_t status,
                         int reps = 1);
    token_row_t row;
    row.kind       = kind;
    row.number     = number;
    row.op         = op;
    row.known      = known;
    row.res.top    = top;
    row.res.depth  = depth;
    row.res.status = status;
    row.reps       = reps;
    token_plan.push_back(row);
  endtask

  initial begin
    int                  phase_idle [4];
    int                  phase_stall [4];
    int                  push_pct;
    logic                kind;
    logic [NUMBER_W-1:0] number;
    op_t                 op;

    phase_idle  = '{0, 81, 0, 26};
    phase_stall = '{0, 0, 81, 26};

    // operators on an empty or single-entry stack, wrap on add
    add_row(KIND_OP,   31'h1234,     OP_ADD, 1'b1, 32'h0,        5'd0,  ST_UNDER);
    add_row(KIND_PUSH, 31'h7fffffff, OP_MUL, 1'b1, 32'h7fffffff, 5'd1,  ST_OK);
    add_row(KIND_OP,   31'h0,        OP_MUL, 1'b1, 32'h7fffffff, 5'd1,  ST_UNDER);
    add_row(KIND_PUSH, 31'h1,        OP_ADD, 1'b1, 32'h1,        5'd2,  ST_OK);
    add_row(KIND_OP,   31'h7fffffff, OP_ADD, 1'b1, 32'h80000000, 5'd1,  ST_OK);
    // divide by zero leaves both operands in place
    add_row(KIND_PUSH, 31'h0,        OP_DIV, 1'b1, 32'h0,        5'd2,  ST_OK);
    add_row(KIND_OP,   31'h0,        OP_DIV, 1'b1, 32'h0,        5'd2,  ST_DIVZ);
    add_row(KIND_OP,   31'h0,        OP_SUB, 1'b1, 32'h80000000, 5'd1,  ST_OK);
    // most negative divided by minus one wraps
    add_row(KIND_PUSH, 31'h0,        OP_ADD, 1'b1, 32'h0,        5'd2,  ST_OK);
    add_row(KIND_PUSH, 31'h1,        OP_ADD, 1'b1, 32'h1,        5'd3,  ST_OK);
    add_row(KIND_OP,   31'h0,        OP_SUB, 1'b1, 32'hffffffff, 5'd2,  ST_OK);
    add_row(KIND_OP,   31'h0,        OP_DIV, 1'b1, 32'h80000000, 5'd1,  ST_OK);
    add_row(KIND_PUSH, 31'h3,        OP_SUB, 1'b1, 32'h3,        5'd2,  ST_OK);
    add_row(KIND_OP,   31'h0,        OP_MUL, 1'b1, 32'h80000000, 5'd1,  ST_OK);
    // 7 / -2 truncates toward zero
    add_row(KIND_PUSH, 31'h7,        OP_ADD, 1'b1, 32'h7,        5'd2,  ST_OK);
    add_row(KIND_PUSH, 31'h0,        OP_ADD, 1'b1, 32'h0,        5'd3,  ST_OK);
    add_row(KIND_PUSH, 31'h2,        OP_ADD, 1'b1, 32'h2,        5'd4,  ST_OK);
    add_row(KIND_OP,   31'h0,        OP_SUB, 1'b1, 32'hfffffffe, 5'd3,  ST_OK);
    add_row(KIND_OP,   31'h0,        OP_DIV, 1'b1, 32'hfffffffd, 5'd2,  ST_OK);
    // fill to the top, then push onto a full stack
    add_row(KIND_PUSH, 31'h55555555, OP_DIV, 1'b0, '0, '0, ST_OK, 14);
    add_row(KIND_PUSH, 31'h2aaaaaaa, OP_ADD, 1'b1, 32'h55555555, 5'd16, ST_OVER);
    add_row(KIND_OP,   31'h0,        OP_SUB, 1'b1, 32'h0,        5'd15, ST_OK);
    add_row(KIND_OP,   31'h0,        OP_DIV, 1'b1, 32'h0,        5'd15, ST_DIVZ);
    add_row(KIND_OP,   31'h2aaaaaaa, OP_MUL, 1'b0, '0, '0, ST_OK);
    add_row(KIND_PUSH, 31'h7fffffff, OP_SUB, 1'b0, '0, '0, ST_OK);
    add_row(KIND_OP,   31'h0,        OP_MUL, 1'b0, '0, '0, ST_OK);

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (token_plan[i]) begin
      for (int r = 0; r < token_plan[i].reps; r++) begin
        send_token(token_plan[i].kind, token_plan[i].number, token_plan[i].op,
                   token_plan[i].known, token_plan[i].res);
      end
    end

    push_pct = 50;
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = phase_idle[phase];
      stall_pct = phase_stall[phase];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // runs of growing, shrinking and balanced streams reach both stack limits
        if (n % 16 == 0) begin
          case ($urandom_range(2))
            0: push_pct = 75;
            1: push_pct = 25;
            default: push_pct = 50;
          endcase
        end
        kind = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_OP;
        case ($urandom_range(7))
          0: number = '0;
          1: number = 31'h1;
          2: number = '1;
          3, 4: number = NUMBER_W'($urandom_range(15));
          default: number = NUMBER_W'($urandom);
        endcase
        op = op_t'($urandom_range(3));
        send_token(kind, number, op, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
